>>> rtl/ccns_pkg.sv
// Shared types, register codes and helper functions of the cover-crop scaler.
package ccns_pkg;

    localparam int DIM_W      = 13;  // clamped source dimension, 1..4096
    localparam int POS_W      = 13;  // display coordinate plus crop offset
    localparam int COORD_W    = 12;
    localparam int STEP_W     = 20;  // Q4.16 source step
    localparam int ADDR_W     = 26;
    localparam int STRIDE_W   = 15;
    localparam int PB_W       = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_ROW_STRIDE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_PIXEL_BYTES = 3'd3;

    localparam logic [DIM_W-1:0]    RST_SRC_WIDTH       = 13'd258;
    localparam logic [DIM_W-1:0]    RST_SRC_HEIGHT      = 13'd960;
    localparam logic [STRIDE_W-1:0] RST_SRC_ROW_STRIDE  = 15'd1032;
    localparam logic [PB_W-1:0]     RST_SRC_PIXEL_BYTES = 3'd4;

    localparam logic [PB_W-1:0]     PIXEL_BYTES_RGB     = 3'd3;
    localparam logic [STEP_W-1:0]   STEP_MAX            = 20'hFFFFF;
    localparam logic [COORD_W-1:0]  OFFSET_MAX          = 12'hFFF;
    localparam logic [DIM_W-1:0]    DIM_MAX             = 13'd4096;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    typedef struct packed {
        logic [8:0] out_x;
        logic [9:0] out_y;
    } t_coord;

    typedef struct packed {
        logic [COORD_W-1:0] src_col;
        logic [COORD_W-1:0] src_row;
        logic [ADDR_W-1:0]  src_address;
        logic               force_opaque;
    } t_result;

    typedef struct packed {
        logic [DIM_W-1:0]    src_width;
        logic [DIM_W-1:0]    src_height;
        logic [STRIDE_W-1:0] src_row_stride;
        logic [PB_W-1:0]     src_pixel_bytes;
    } t_cfg;

    typedef struct packed {
        logic               valid;
        logic [STEP_W-1:0]  step;
        logic [COORD_W-1:0] crop_x;
        logic [COORD_W-1:0] crop_y;
    } t_scale;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
    } t_pos;

    typedef enum logic [2:0] {
        D_PROD,
        D_STEP_LD,
        D_STEP_RUN,
        D_SCL_LD,
        D_SCL_RUN,
        D_FINISH,
        D_DONE
    } t_drv_state;

    function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_MAX) begin
            r = DIM_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> rtl/ccns_derive.sv
// Configuration registers and the sequencer that derives step and crop offsets.
module ccns_derive #(
    parameter int DISP_WIDTH  = 258,
    parameter int DISP_HEIGHT = 960
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ccns_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ccns_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output ccns_pkg::t_cfg                    o_cfg,
    output ccns_pkg::t_scale                  o_scale
);

    localparam logic [ccns_pkg::DIM_W-1:0] DW = ccns_pkg::DIM_W'(DISP_WIDTH);
    localparam logic [ccns_pkg::DIM_W-1:0] DH = ccns_pkg::DIM_W'(DISP_HEIGHT);

    ccns_pkg::t_drv_state r_state, n_state;
    ccns_pkg::t_cfg       r_cfg;

    logic [ccns_pkg::DIM_W-1:0]     r_sw, r_sh;
    logic [2*ccns_pkg::DIM_W-1:0]   r_prod_w, r_prod_h;
    logic [31:0]                    r_num;
    logic [13:0]                    r_rem;
    logic [13:0]                    r_den;
    logic [4:0]                     r_cnt;
    logic [ccns_pkg::STEP_W-1:0]    r_step;
    logic [ccns_pkg::COORD_W-1:0]   r_crop_x, r_crop_y;

    logic        cfg_hit;
    logic        axis_w;
    logic        div_load, div_run, cap_step, cap_crop;
    logic [31:0] ld_num;
    logic [13:0] ld_den;
    logic [14:0] trial;
    logic        qbit;
    logic [31:0] n_num;
    logic [13:0] n_rem;
    logic [ccns_pkg::COORD_W-1:0] crop_val;

    function automatic logic [ccns_pkg::COORD_W-1:0] crop_of(
        input logic [31:0] scaled, input logic [ccns_pkg::DIM_W-1:0] disp);
        logic [31:0] half;
        logic [ccns_pkg::COORD_W-1:0] r;
        half = (scaled - 32'(disp)) >> 1;
        if (scaled <= 32'(disp)) begin
            r = '0;
        end else if (half > 32'(ccns_pkg::OFFSET_MAX)) begin
            r = ccns_pkg::OFFSET_MAX;
        end else begin
            r = half[ccns_pkg::COORD_W-1:0];
        end
        return r;
    endfunction

    assign cfg_hit = i_cfg_we && (i_cfg_index <= ccns_pkg::REG_SRC_PIXEL_BYTES);

    // Scale along width when the width product wins; a tie goes to height.
    assign axis_w = r_prod_w > r_prod_h;

    // Next state: any accepted write restarts the derivation.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ccns_pkg::D_PROD:     n_state = ccns_pkg::D_STEP_LD;
            ccns_pkg::D_STEP_LD:  n_state = ccns_pkg::D_STEP_RUN;
            ccns_pkg::D_STEP_RUN: if (r_cnt == 5'd31) n_state = ccns_pkg::D_SCL_LD;
            ccns_pkg::D_SCL_LD:   n_state = ccns_pkg::D_SCL_RUN;
            ccns_pkg::D_SCL_RUN:  if (r_cnt == 5'd31) n_state = ccns_pkg::D_FINISH;
            ccns_pkg::D_FINISH:   n_state = ccns_pkg::D_DONE;
            ccns_pkg::D_DONE:     n_state = ccns_pkg::D_DONE;
            default:              n_state = ccns_pkg::D_PROD;
        endcase
        if (cfg_hit) n_state = ccns_pkg::D_PROD;
    end

    // Sequencer outputs.
    always_comb begin
        div_load = 1'b0;
        div_run  = 1'b0;
        cap_step = 1'b0;
        cap_crop = 1'b0;
        unique case (r_state)
            ccns_pkg::D_STEP_LD:  div_load = 1'b1;
            ccns_pkg::D_STEP_RUN: div_run  = 1'b1;
            ccns_pkg::D_SCL_LD: begin
                div_load = 1'b1;
                cap_step = 1'b1;
            end
            ccns_pkg::D_SCL_RUN:  div_run  = 1'b1;
            ccns_pkg::D_FINISH:   cap_crop = 1'b1;
            default: begin
            end
        endcase
    end

    // Divider operands: rounded quotient as (2*num + den) / (2*den).
    always_comb begin
        if (r_state == ccns_pkg::D_STEP_LD) begin
            if (axis_w) begin
                ld_num = 32'({r_sw, 17'b0}) + 32'(DW);
                ld_den = {DW, 1'b0};
            end else begin
                ld_num = 32'({r_sh, 17'b0}) + 32'(DH);
                ld_den = {DH, 1'b0};
            end
        end else begin
            if (axis_w) begin
                ld_num = 32'({r_prod_w, 1'b0}) + 32'(r_sw);
                ld_den = {r_sw, 1'b0};
            end else begin
                ld_num = 32'({r_prod_h, 1'b0}) + 32'(r_sh);
                ld_den = {r_sh, 1'b0};
            end
        end
    end

    // One restoring division step per cycle.
    always_comb begin
        trial = {r_rem, r_num[31]};
        qbit  = trial >= {1'b0, r_den};
        n_rem = qbit ? 14'(trial - {1'b0, r_den}) : trial[13:0];
        n_num = {r_num[30:0], qbit};
    end

    assign crop_val = axis_w ? crop_of(r_num, DH) : crop_of(r_num, DW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state                <= ccns_pkg::D_PROD;
            r_cfg.src_width        <= ccns_pkg::RST_SRC_WIDTH;
            r_cfg.src_height       <= ccns_pkg::RST_SRC_HEIGHT;
            r_cfg.src_row_stride   <= ccns_pkg::RST_SRC_ROW_STRIDE;
            r_cfg.src_pixel_bytes  <= ccns_pkg::RST_SRC_PIXEL_BYTES;
            r_step                 <= '0;
            r_crop_x               <= '0;
            r_crop_y               <= '0;
            r_cnt                  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ccns_pkg::REG_SRC_WIDTH:
                        r_cfg.src_width <= i_cfg_data[ccns_pkg::DIM_W-1:0];
                    ccns_pkg::REG_SRC_HEIGHT:
                        r_cfg.src_height <= i_cfg_data[ccns_pkg::DIM_W-1:0];
                    ccns_pkg::REG_SRC_ROW_STRIDE:
                        r_cfg.src_row_stride <= i_cfg_data;
                    ccns_pkg::REG_SRC_PIXEL_BYTES:
                        r_cfg.src_pixel_bytes <= i_cfg_data[ccns_pkg::PB_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (div_load) r_cnt <= '0;
            else if (div_run) r_cnt <= r_cnt + 5'd1;
            if (cap_step) begin
                r_step <= (r_num > 32'(ccns_pkg::STEP_MAX)) ? ccns_pkg::STEP_MAX
                                                            : r_num[ccns_pkg::STEP_W-1:0];
            end
            if (cap_crop) begin
                r_crop_x <= axis_w ? '0 : crop_val;
                r_crop_y <= axis_w ? crop_val : '0;
            end
        end
    end

    // Clamp the dimensions and form both axis products before the first divide.
    always_ff @(posedge i_clk) begin
        if (r_state == ccns_pkg::D_PROD) begin
            r_sw     <= ccns_pkg::dim_clamp(r_cfg.src_width);
            r_sh     <= ccns_pkg::dim_clamp(r_cfg.src_height);
            r_prod_w <= 26'(DW) * 26'(ccns_pkg::dim_clamp(r_cfg.src_height));
            r_prod_h <= 26'(DH) * 26'(ccns_pkg::dim_clamp(r_cfg.src_width));
        end
        if (div_load) begin
            r_num <= ld_num;
            r_den <= ld_den;
            r_rem <= '0;
        end else if (div_run) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_cfg          = r_cfg;
    assign o_scale.valid  = (r_state == ccns_pkg::D_DONE);
    assign o_scale.step   = r_step;
    assign o_scale.crop_x = r_crop_x;
    assign o_scale.crop_y = r_crop_y;

endmodule

>>> rtl/ccns_front.sv
// Input side: accept display coordinates and add the crop offsets.
module ccns_front (
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ccns_pkg::t_coord  i_in_item,
    input  ccns_pkg::t_scale  i_scale,
    input  logic              i_full,
    output logic              o_push,
    output ccns_pkg::t_pos    o_pos
);

    // Hold off while the scale values are being derived or the queue is full.
    assign o_in_ready  = i_scale.valid && !i_full;
    assign o_push      = i_in_valid && o_in_ready;
    assign o_pos.pos_x = ccns_pkg::POS_W'(i_in_item.out_x) + ccns_pkg::POS_W'(i_scale.crop_x);
    assign o_pos.pos_y = ccns_pkg::POS_W'(i_in_item.out_y) + ccns_pkg::POS_W'(i_scale.crop_y);

endmodule

>>> rtl/ccns_fifo.sv
// Short queue between the front and back parts.
module ccns_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ccns_pkg::t_pos  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output ccns_pkg::t_pos  o_data
);

    ccns_pkg::t_pos               r_mem [ccns_pkg::FIFO_DEPTH];
    logic [ccns_pkg::FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [ccns_pkg::FIFO_AW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

    assign o_full  = (r_count == (ccns_pkg::FIFO_AW+1)'(ccns_pkg::FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

>>> rtl/ccns_back.sv
// Back part: scale, clamp and address pipeline with the output register.
module ccns_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  ccns_pkg::t_pos     i_pos,
    output logic               o_pop,
    input  ccns_pkg::t_cfg     i_cfg,
    input  ccns_pkg::t_scale   i_scale,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ccns_pkg::t_result  o_out_item
);

    localparam int RAW_W = ccns_pkg::POS_W + ccns_pkg::STEP_W - 16;
    localparam int PROD_W = ccns_pkg::POS_W + ccns_pkg::STEP_W;
    localparam int ROFF_W = ccns_pkg::COORD_W + ccns_pkg::STRIDE_W;
    localparam int COFF_W = ccns_pkg::COORD_W + ccns_pkg::PB_W;

    logic r_v1, r_v2, r_v3, r_v4;
    logic adv1, adv2, adv3, adv4;

    logic [RAW_W-1:0]             r_s1_col, r_s1_row;
    logic [ccns_pkg::COORD_W-1:0] r_s2_col, r_s2_row;
    logic [ccns_pkg::COORD_W-1:0] r_s3_col, r_s3_row;
    logic [ROFF_W-1:0]            r_s3_row_off;
    logic [COFF_W-1:0]            r_s3_col_off;
    ccns_pkg::t_result            r_out;

    logic [PROD_W-1:0]            prod_x, prod_y;
    logic [ccns_pkg::DIM_W-1:0]   dim_w, dim_h;
    logic [ccns_pkg::COORD_W-1:0] col_c, row_c;
    logic [ROFF_W:0]              addr_sum;

    // Advance a stage when it is empty or the next one advances.
    assign adv4  = !r_v4 || i_out_ready;
    assign adv3  = !r_v3 || adv4;
    assign adv2  = !r_v2 || adv3;
    assign adv1  = !r_v1 || adv2;
    assign o_pop = adv1 && i_valid;

    assign prod_x = PROD_W'(i_pos.pos_x) * PROD_W'(i_scale.step);
    assign prod_y = PROD_W'(i_pos.pos_y) * PROD_W'(i_scale.step);

    assign dim_w = ccns_pkg::dim_clamp(i_cfg.src_width);
    assign dim_h = ccns_pkg::dim_clamp(i_cfg.src_height);

    // Clamp to the last column or row.
    assign col_c = (r_s1_col >= RAW_W'(dim_w)) ? ccns_pkg::COORD_W'(dim_w - 1'b1)
                                               : r_s1_col[ccns_pkg::COORD_W-1:0];
    assign row_c = (r_s1_row >= RAW_W'(dim_h)) ? ccns_pkg::COORD_W'(dim_h - 1'b1)
                                               : r_s1_row[ccns_pkg::COORD_W-1:0];

    assign addr_sum = (ROFF_W+1)'(r_s3_row_off) + (ROFF_W+1)'(r_s3_col_off);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
            if (adv4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1_col <= prod_x[PROD_W-1:16];
            r_s1_row <= prod_y[PROD_W-1:16];
        end
        if (adv2) begin
            r_s2_col <= col_c;
            r_s2_row <= row_c;
        end
        if (adv3) begin
            r_s3_col     <= r_s2_col;
            r_s3_row     <= r_s2_row;
            r_s3_row_off <= ROFF_W'(r_s2_row) * ROFF_W'(i_cfg.src_row_stride);
            r_s3_col_off <= COFF_W'(r_s2_col) * COFF_W'(i_cfg.src_pixel_bytes);
        end
        if (adv4) begin
            r_out.src_col      <= r_s3_col;
            r_out.src_row      <= r_s3_row;
            r_out.src_address  <= addr_sum[ccns_pkg::ADDR_W-1:0];
            r_out.force_opaque <= (i_cfg.src_pixel_bytes == ccns_pkg::PIXEL_BYTES_RGB);
        end
    end

    assign o_out_valid = r_v4;
    assign o_out_item  = r_out;

endmodule

>>> rtl/cover_crop_nearest_scaler.sv
// Top level of the cover-and-crop nearest-neighbor scaler address generator.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) takes one display
//   pixel coordinate per transfer. Output channel (o_out_valid / i_out_ready /
//   o_out_item) gives one source column, row, byte address and force-opaque
//   flag per input, in order.
//   Configuration: write source width, height, row stride and pixel bytes
//   through i_cfg_we / i_cfg_index / i_cfg_data; writes to an index past the
//   last register are dropped.
//   Throughput: one transfer per cycle on both channels unless stalled.
//   A result passes the queue, stages s1 to s3 and the output register.
//   After reset and after every register write the derivation sequencer runs
//   (a divide for the step and another for the scaled size); o_in_ready
//   stays low until it reaches its done state.
//   Synchronous reset clears the queue and pipeline, loads the default
//   registers and starts the derivation.
//   When the receiver stalls, the output register holds its result; the
//   pipeline and the 4-entry queue fill up, and o_in_ready falls only when
//   the queue is full.
module cover_crop_nearest_scaler #(
    parameter int DISP_WIDTH  = 258,
    parameter int DISP_HEIGHT = 960
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  ccns_pkg::t_coord                 i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output ccns_pkg::t_result                o_out_item,
    input  logic                             i_cfg_we,
    input  logic [ccns_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ccns_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    ccns_pkg::t_cfg   cfg;
    ccns_pkg::t_scale scale;
    ccns_pkg::t_pos   push_pos, head_pos;
    logic             push, full, pop, head_valid;

    // Registers plus step and crop derivation.
    ccns_derive #(
        .DISP_WIDTH  (DISP_WIDTH),
        .DISP_HEIGHT (DISP_HEIGHT)
    ) u_derive (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_scale     (scale)
    );

    // Front: take coordinates and shift them by the crop offsets.
    ccns_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_scale    (scale),
        .i_full     (full),
        .o_push     (push),
        .o_pos      (push_pos)
    );

    // Decouple the front from back-end stalls.
    ccns_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_pos),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_data  (head_pos)
    );

    // Back: scale, clamp, form the address and present the result.
    ccns_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (head_valid),
        .i_pos       (head_pos),
        .o_pop       (pop),
        .i_cfg       (cfg),
        .i_scale     (scale),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

>>> rtl/ccns_checker.sv
// Port-level checker of the scaler, bound to the top level.
module ccns_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             o_in_ready,
    input  logic                             o_out_valid,
    input  logic                             i_out_ready,
    input  ccns_pkg::t_result                o_out_item,
    input  logic                             i_cfg_we,
    input  logic [ccns_pkg::CFG_IDX_W-1:0]   i_cfg_index
);

    // Reset empties the pipeline.
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Reset starts derivation, so no input is taken right after it.
    a_reset_ready: assert property (@(posedge i_clk) !i_rst_n |=> !o_in_ready)
        else $error("input ready right after reset");

    // A register write restarts derivation and closes the input.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_index <= ccns_pkg::REG_SRC_PIXEL_BYTES)) |=> !o_in_ready)
        else $error("input ready after a register write");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

endmodule

bind cover_crop_nearest_scaler ccns_checker u_ccns_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_index (i_cfg_index)
);

>>> sim/cover_crop_nearest_scaler_tb.sv
// Self-checking testbench for the cover-and-crop nearest-neighbor scaler.
module cover_crop_nearest_scaler_tb;

    localparam int DISP_W         = 258;
    localparam int DISP_H         = 960;
    localparam int CLK_PERIOD     = 10;
    localparam int PIPE_LATENCY   = 4;      // added to the settling wait at the end of a drain
    localparam int DRAIN_LIMIT    = 4000;   // covers a hold-off plus a derivation pass
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int RAND_PHASES    = 12;
    localparam int PHASE_ITEMS    = 62;
    localparam int HOLD_AT        = 300;    // result count that starts the long hold-off
    localparam int HOLD_CYCLES    = 150;
    localparam int CALM_FROM      = 450;    // transfer counts with no random idling
    localparam int CALM_TO        = 560;
    localparam int MAX_REPORTS    = 10;

    // Index past the last register; writes there must be dropped.
    localparam logic [ccns_pkg::CFG_IDX_W-1:0] REG_PAST_END = 3'd7;

    // ------------------------------------------------------------------
    // Scoreboard: mirrors the register file and the derived scale values,
    // turns every accepted coordinate into the expected source fetch and
    // matches results in order.
    // ------------------------------------------------------------------
    class fetch_addr_book;
        ccns_pkg::t_result             fetch_q[$];
        logic [ccns_pkg::DIM_W-1:0]    width_reg;
        logic [ccns_pkg::DIM_W-1:0]    height_reg;
        logic [ccns_pkg::STRIDE_W-1:0] stride_reg;
        logic [ccns_pkg::PB_W-1:0]     pbytes_reg;
        longint unsigned               src_step;
        longint unsigned               crop_x;
        longint unsigned               crop_y;
        int                            errors;

        function new();
            width_reg  = ccns_pkg::RST_SRC_WIDTH;
            height_reg = ccns_pkg::RST_SRC_HEIGHT;
            stride_reg = ccns_pkg::RST_SRC_ROW_STRIDE;
            pbytes_reg = ccns_pkg::RST_SRC_PIXEL_BYTES;
            errors     = 0;
            rederive();
        endfunction

        function longint unsigned clamp_dim(logic [ccns_pkg::DIM_W-1:0] v);
            if (v == '0) return 1;
            if (v > 13'd4096) return 4096;
            return v;
        endfunction

        // Round to nearest, halves up, exact in integers.
        function longint unsigned round_div(longint unsigned num, longint unsigned den);
            return (2 * num + den) / (2 * den);
        endfunction

        function longint unsigned half_crop(longint unsigned scaled, longint unsigned disp);
            longint unsigned off;
            if (scaled <= disp) return 0;
            off = (scaled - disp) / 2;
            return (off > ccns_pkg::OFFSET_MAX) ? ccns_pkg::OFFSET_MAX : off;
        endfunction

        function void rederive();
            longint unsigned sw, sh, dw, dh, s, fit_w, fit_h;
            sw = clamp_dim(width_reg);
            sh = clamp_dim(height_reg);
            dw = DISP_W;
            dh = DISP_H;
            // Scale along the axis that needs the larger factor; a tie goes to height.
            if (dw * sh > dh * sw) begin
                s     = round_div(sw << 16, dw);
                fit_w = dw;
                fit_h = round_div(sh * dw, sw);
            end else begin
                s     = round_div(sh << 16, dh);
                fit_h = dh;
                fit_w = round_div(sw * dh, sh);
            end
            src_step = (s > ccns_pkg::STEP_MAX) ? ccns_pkg::STEP_MAX : s;
            crop_x   = half_crop(fit_w, dw);
            crop_y   = half_crop(fit_h, dh);
        endfunction

        function void set_reg(logic [ccns_pkg::CFG_IDX_W-1:0] idx,
                              logic [ccns_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                ccns_pkg::REG_SRC_WIDTH:       width_reg  = data[ccns_pkg::DIM_W-1:0];
                ccns_pkg::REG_SRC_HEIGHT:      height_reg = data[ccns_pkg::DIM_W-1:0];
                ccns_pkg::REG_SRC_ROW_STRIDE:  stride_reg = data[ccns_pkg::STRIDE_W-1:0];
                ccns_pkg::REG_SRC_PIXEL_BYTES: pbytes_reg = data[ccns_pkg::PB_W-1:0];
                default:                       return;
            endcase
            rederive();
        endfunction

        function longint unsigned map_pos(longint unsigned pos, longint unsigned off,
                                          longint unsigned dim);
            longint unsigned s;
            s = ((pos + off) * src_step) >> 16;
            return (s >= dim) ? dim - 1 : s;
        endfunction

        function void note_coord(ccns_pkg::t_coord c);
            ccns_pkg::t_result r;
            longint unsigned   col, row, addr;
            col  = map_pos(c.out_x, crop_x, clamp_dim(width_reg));
            row  = map_pos(c.out_y, crop_y, clamp_dim(height_reg));
            addr = row * stride_reg + col * pbytes_reg;
            r.src_col      = col[ccns_pkg::COORD_W-1:0];
            r.src_row      = row[ccns_pkg::COORD_W-1:0];
            r.src_address  = addr[ccns_pkg::ADDR_W-1:0];
            r.force_opaque = (pbytes_reg == ccns_pkg::PIXEL_BYTES_RGB);
            fetch_q.push_back(r);
        endfunction

        function void check_result(ccns_pkg::t_result got);
            ccns_pkg::t_result want;
            if (fetch_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: col %0d row %0d addr 0x%0h opaque %0b",
                             got.src_col, got.src_row, got.src_address, got.force_opaque);
                return;
            end
            want = fetch_q.pop_front();
            if (got.src_col !== want.src_col || got.src_row !== want.src_row ||
                got.src_address !== want.src_address ||
                got.force_opaque !== want.force_opaque) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("mismatch: expected col %0d row %0d addr 0x%0h opaque %0b",
                             want.src_col, want.src_row, want.src_address,
                             want.force_opaque);
                    $display("          got      col %0d row %0d addr 0x%0h opaque %0b",
                             got.src_col, got.src_row, got.src_address, got.force_opaque);
                end
            end
        endfunction

        function int pending();
            return fetch_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Block hookup. Every input holds a known value from time zero.
    // ------------------------------------------------------------------
    logic                            i_clk     = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    ccns_pkg::t_coord                in_item   = '0;
    logic                            out_ready = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [ccns_pkg::CFG_IDX_W-1:0]  cfg_index = ccns_pkg::REG_SRC_WIDTH;
    logic [ccns_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            in_ready;
    logic                            out_valid;
    ccns_pkg::t_result               out_item;

    fetch_addr_book book = new();
    int in_count  = 0;
    int out_count = 0;

    cover_crop_nearest_scaler #(
        .DISP_WIDTH (DISP_W),
        .DISP_HEIGHT(DISP_H)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("cover_crop_nearest_scaler_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender side. All tasks run at a rising edge and drive with NBAs, and
    // sample the block right after the edge, so they see pre-edge values.
    // ------------------------------------------------------------------

    // Offer one coordinate and hold it until the transfer happens.
    task automatic send_coord(input ccns_pkg::t_coord c);
        // Idle at random, except in the calm stretch.
        while (!(in_count >= CALM_FROM && in_count < CALM_TO) && $urandom_range(99) < 6) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= c;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        book.note_coord(c);
        in_count++;
    endtask

    // Drop valid and wait for every outstanding fetch to come back.
    task automatic drain();
        int n;
        in_valid <= 1'b0;
        n = 0;
        while (book.pending() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    // Write all four registers back to back, then one write past the end
    // of the register list that the block must drop.
    task automatic configure(input logic [ccns_pkg::CFG_DATA_W-1:0] w,
                             input logic [ccns_pkg::CFG_DATA_W-1:0] h,
                             input logic [ccns_pkg::CFG_DATA_W-1:0] stride,
                             input logic [ccns_pkg::CFG_DATA_W-1:0] pbytes,
                             input logic [ccns_pkg::CFG_IDX_W-1:0]  stray_idx);
        logic [ccns_pkg::CFG_IDX_W-1:0]  idx [5];
        logic [ccns_pkg::CFG_DATA_W-1:0] val [5];
        idx = '{ccns_pkg::REG_SRC_WIDTH, ccns_pkg::REG_SRC_HEIGHT,
                ccns_pkg::REG_SRC_ROW_STRIDE, ccns_pkg::REG_SRC_PIXEL_BYTES, stray_idx};
        val = '{w, h, stride, pbytes, 15'h7FFF};
        for (int k = 0; k < 5; k++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            @(posedge i_clk);
            book.set_reg(idx[k], val[k]);
        end
        cfg_we <= 1'b0;
    endtask

    // Image corners and just past the display edge, plus the field maximums.
    task automatic send_corners();
        ccns_pkg::t_coord c;
        c = '{out_x: 9'd0,   out_y: 10'd0};    send_coord(c);
        c = '{out_x: 9'd257, out_y: 10'd959};  send_coord(c);
        c = '{out_x: 9'd258, out_y: 10'd960};  send_coord(c);
        c = '{out_x: 9'd511, out_y: 10'd1023}; send_coord(c);
    endtask

    // Source dimension: mostly legal sizes, often tiny ones, and now and
    // then the whole register range including zero and oversized values.
    function automatic logic [ccns_pkg::CFG_DATA_W-1:0] pick_dim();
        case ($urandom_range(9))
            0:       return ccns_pkg::CFG_DATA_W'($urandom_range(8191));
            1, 2, 3: return ccns_pkg::CFG_DATA_W'($urandom_range(1, 64));
            default: return ccns_pkg::CFG_DATA_W'($urandom_range(1, 4096));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver side: check every result transfer, stall at random, and
    // once hold ready low long enough for the queue to fill and the input
    // to back up.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int hold_left;
        bit held_once;
        hold_left = 0;
        held_once = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rst_n && out_ready && out_valid) begin
                book.check_result(out_item);
                out_count++;
            end
            if (!held_once && out_count >= HOLD_AT) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= (out_count >= CALM_FROM && out_count < CALM_TO) ||
                             ($urandom_range(99) >= 6);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin : stimulus
        ccns_pkg::t_coord c;
        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: display-sized source, a tie between the axes.
        send_corners();

        // Smallest source, 3-byte pixels.
        drain();
        configure(15'd1, 15'd1, 15'd1, 15'(ccns_pkg::PIXEL_BYTES_RGB), REG_PAST_END);
        send_corners();

        // Very wide source: the left crop saturates; widest stride on a single source row.
        drain();
        configure(15'd4096, 15'd1, 15'h7FFF, 15'(ccns_pkg::RST_SRC_PIXEL_BYTES),
                  REG_PAST_END);
        send_corners();

        // Very tall source: the top crop saturates; zero stride.
        drain();
        configure(15'd1, 15'd4096, 15'd0, 15'(ccns_pkg::PIXEL_BYTES_RGB), REG_PAST_END);
        send_corners();

        // Zero width and oversized height get clamped; odd pixel size of zero.
        drain();
        configure(15'd0, 15'd8191, 15'd16384, 15'd0, REG_PAST_END);
        send_corners();

        // Oversized width, zero height, widest pixel size field.
        drain();
        configure(15'd8191, 15'd0, 15'd12345, 15'd7, REG_PAST_END);
        send_corners();

        // Random settings, each followed by a burst of coordinates. Most
        // coordinates stay on the display; some use the full field range.
        for (int p = 0; p < RAND_PHASES; p++) begin
            drain();
            configure(pick_dim(), pick_dim(),
                      ($urandom_range(3) == 0)
                          ? ccns_pkg::CFG_DATA_W'($urandom_range(32767))
                          : ccns_pkg::CFG_DATA_W'($urandom_range(1, 16384)),
                      ($urandom_range(4) == 0)
                          ? ccns_pkg::CFG_DATA_W'($urandom_range(7))
                          : ccns_pkg::CFG_DATA_W'($urandom_range(3, 4)),
                      REG_PAST_END - ccns_pkg::CFG_IDX_W'($urandom_range(3)));
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                c.out_x = ($urandom_range(4) == 0) ? 9'($urandom_range(511))
                                                   : 9'($urandom_range(257));
                c.out_y = ($urandom_range(4) == 0) ? 10'($urandom_range(1023))
                                                   : 10'($urandom_range(959));
                send_coord(c);
            end
        end

        drain();
        if (book.pending() != 0) begin
            $display("%0d expected results never arrived", book.pending());
            book.errors++;
        end
        if (book.errors == 0) begin
            $display("cover_crop_nearest_scaler_tb: PASS");
        end else begin
            $display("cover_crop_nearest_scaler_tb: FAIL");
        end
        $finish;
    end

endmodule
